// ===== rtl/core/trce_pkg.sv =====
// package: types, codes and constants shared by the tftp read client engine
`default_nettype none

package trce_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_PACKET = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_ABORT  = 2'd3;

  localparam logic [15:0] OPCODE_DATA = 16'd3;
  localparam logic [9:0]  FULL_BLOCK  = 10'd512;

  localparam logic [2:0] CFG_SERVER_IP    = 3'd0;
  localparam logic [2:0] CFG_SERVER_PORT  = 3'd1;
  localparam logic [2:0] CFG_RETRY_TICKS  = 3'd2;
  localparam logic [2:0] CFG_IDLE_TICKS   = 3'd3;
  localparam logic [2:0] CFG_MAX_REQUESTS = 3'd4;

  localparam logic [31:0] RST_SERVER_IP    = 32'd0;
  localparam logic [15:0] RST_SERVER_PORT  = 16'd69;
  localparam logic [15:0] RST_RETRY_TICKS  = 16'd100;
  localparam logic [15:0] RST_IDLE_TICKS   = 16'd2000;
  localparam logic [2:0]  RST_MAX_REQUESTS = 3'd5;

  localparam logic [2:0] STATUS_RUNNING  = 3'd0;
  localparam logic [2:0] STATUS_SUCCESS  = 3'd1;
  localparam logic [2:0] STATUS_ABORTED  = 3'd2;
  localparam logic [2:0] STATUS_NO_REPLY = 3'd3;
  localparam logic [2:0] STATUS_IDLE_TO  = 3'd4;

  typedef enum logic [2:0] {
    EV_START,
    EV_DATA,
    EV_OTHER_PKT,
    EV_TICK,
    EV_ABORT
  } ev_kind_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] pkt_opcode;
    logic [31:0] pkt_source_ip;
    logic [15:0] pkt_source_port;
    logic [15:0] pkt_block;
    logic [9:0]  pkt_payload_len;
  } trce_in_t;

  typedef struct packed {
    logic        send_request;
    logic        send_ack;
    logic [15:0] ack_block;
    logic [15:0] ack_port;
    logic        data_accept;
    logic [31:0] write_offset;
    logic [9:0]  accepted_length;
    logic        progress_mark;
    logic        finished;
    logic [2:0]  status;
    logic [31:0] total_length;
  } trce_out_t;

  typedef struct packed {
    ev_kind_t    kind;
    logic [15:0] src_port;
    logic [15:0] block;
    logic [9:0]  len;
  } trce_event_t;

  typedef struct packed {
    logic [15:0] server_port;
    logic [15:0] retry_ticks;
    logic [15:0] idle_ticks;
    logic [2:0]  max_requests;
  } trce_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/trce_front.sv =====
// front end: classifies incoming beats into events for the back end
`default_nettype none

module trce_front (
  input  trce_pkg::trce_in_t    in_data,
  input  logic [31:0]           server_ip,
  output trce_pkg::trce_event_t ev
);
  import trce_pkg::*;

  always_comb begin
    ev.src_port = in_data.pkt_source_port;
    ev.block    = in_data.pkt_block;
    ev.len      = (in_data.pkt_payload_len > FULL_BLOCK) ? FULL_BLOCK : in_data.pkt_payload_len;
    unique case (in_data.command)
      CMD_START: ev.kind = EV_START;
      CMD_PACKET: begin
        if (in_data.pkt_opcode == OPCODE_DATA && in_data.pkt_source_ip == server_ip) begin
          ev.kind = EV_DATA;
        end else begin
          ev.kind = EV_OTHER_PKT;
        end
      end
      CMD_TICK: ev.kind = EV_TICK;
      default:  ev.kind = EV_ABORT;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/trce_fifo.sv =====
// event queue between front and back ends
`default_nettype none

module trce_fifo #(
  parameter int unsigned DEPTH = trce_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  trce_pkg::trce_event_t push_data,
  input  logic                  pop,
  output logic                  full,
  output logic                  not_empty,
  output trce_pkg::trce_event_t pop_data
);
  import trce_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  trce_event_t   mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/trce_back.sv =====
// back end: transfer state, timers and registered result beat
`default_nettype none

module trce_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ev_valid,
  input  trce_pkg::trce_event_t ev,
  output logic                  ev_pop,
  input  trce_pkg::trce_cfg_t   cfg,
  output logic                  out_valid,
  input  logic                  out_stall,
  output trce_pkg::trce_out_t   out_data
);
  import trce_pkg::*;

  logic        busy_r, busy_nxt;
  logic        started_r, started_nxt;
  logic [15:0] exp_block_r, exp_block_nxt;
  logic [15:0] reply_port_r, reply_port_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [2:0]  req_count_r, req_count_nxt;
  logic [31:0] rx_len_r, rx_len_nxt;
  logic        out_valid_r, out_valid_nxt;
  trce_out_t   out_data_r, res;
  logic [31:0] new_len;
  logic [2:0]  req_inc;

  assign ev_pop    = ev_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign new_len   = rx_len_r + {22'd0, ev.len};
  assign req_inc   = req_count_r + 3'd1;

  always_comb begin
    busy_nxt       = busy_r;
    started_nxt    = started_r;
    exp_block_nxt  = exp_block_r;
    reply_port_nxt = reply_port_r;
    elapsed_nxt    = elapsed_r;
    req_count_nxt  = req_count_r;
    rx_len_nxt     = rx_len_r;
    res            = '0;
    if (ev.kind == EV_START) begin
      busy_nxt         = 1'b1;
      started_nxt      = 1'b0;
      exp_block_nxt    = 16'd1;
      reply_port_nxt   = cfg.server_port;
      elapsed_nxt      = '0;
      req_count_nxt    = '0;
      rx_len_nxt       = '0;
      res.send_request = 1'b1;
    end else if (busy_r) begin
      unique case (ev.kind)
        EV_DATA: begin
          res.total_length = rx_len_r;
          reply_port_nxt   = ev.src_port;
          res.send_ack     = 1'b1;
          res.ack_port     = ev.src_port;
          if (ev.block == exp_block_r) begin
            started_nxt         = 1'b1;
            res.ack_block       = exp_block_r;
            exp_block_nxt       = exp_block_r + 16'd1;
            res.data_accept     = 1'b1;
            res.write_offset    = rx_len_r;
            res.accepted_length = ev.len;
            rx_len_nxt          = new_len;
            res.total_length    = new_len;
            if (ev.len < FULL_BLOCK) begin
              busy_nxt     = 1'b0;
              started_nxt  = 1'b0;
              res.finished = 1'b1;
              res.status   = STATUS_SUCCESS;
            end else begin
              res.progress_mark = (new_len[15:0] == 16'd0);
              elapsed_nxt       = '0;
            end
          end else if (ev.block < exp_block_r) begin
            res.ack_block = ev.block;
          end else begin
            res.ack_block = exp_block_r;
          end
        end
        EV_OTHER_PKT: begin
          res.total_length = rx_len_r;
        end
        EV_TICK: begin
          res.total_length = rx_len_r;
          if (!started_r) begin
            if (elapsed_r >= cfg.retry_ticks) begin
              res.send_request = 1'b1;
              elapsed_nxt      = '0;
              req_count_nxt    = req_inc;
              if (req_inc == cfg.max_requests) begin
                busy_nxt         = 1'b0;
                started_nxt      = 1'b0;
                res.finished     = 1'b1;
                res.status       = STATUS_NO_REPLY;
                res.total_length = '0;
              end
            end else begin
              elapsed_nxt = elapsed_r + 16'd1;
            end
          end else if (elapsed_r >= cfg.idle_ticks) begin
            busy_nxt         = 1'b0;
            started_nxt      = 1'b0;
            res.finished     = 1'b1;
            res.status       = STATUS_IDLE_TO;
            res.total_length = '0;
          end else begin
            elapsed_nxt = elapsed_r + 16'd1;
          end
        end
        EV_ABORT: begin
          busy_nxt     = 1'b0;
          started_nxt  = 1'b0;
          res.finished = 1'b1;
          res.status   = STATUS_ABORTED;
        end
        default: begin
          res.status = STATUS_RUNNING;
        end
      endcase
    end
    out_valid_nxt = ev_pop || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      started_r    <= 1'b0;
      exp_block_r  <= 16'd1;
      reply_port_r <= RST_SERVER_PORT;
      elapsed_r    <= '0;
      req_count_r  <= '0;
      rx_len_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (ev_pop) begin
        busy_r       <= busy_nxt;
        started_r    <= started_nxt;
        exp_block_r  <= exp_block_nxt;
        reply_port_r <= reply_port_nxt;
        elapsed_r    <= elapsed_nxt;
        req_count_r  <= req_count_nxt;
        rx_len_r     <= rx_len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_pop) begin
      out_data_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tftp_read_client_engine.sv =====
// top level: tftp read client engine with configuration registers
// an accepted input beat is written into the event queue, then its result beat is registered in the back end
// throughput: one event per cycle while no result beat is held by out_stall
// the event queue takes a new beat while a result beat waits on out_stall, unless the queue is full
// reset (rst_n low, synchronous): idle, queue empty, registers at defaults
`default_nettype none

module tftp_read_client_engine #(
  parameter int unsigned QUEUE_DEPTH = trce_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  trce_pkg::trce_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output trce_pkg::trce_out_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import trce_pkg::*;

  logic [31:0] server_ip_r;
  trce_cfg_t   cfg_r;
  trce_event_t front_ev, queue_ev;
  logic        q_full, q_not_empty, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_ip_r        <= RST_SERVER_IP;
      cfg_r.server_port  <= RST_SERVER_PORT;
      cfg_r.retry_ticks  <= RST_RETRY_TICKS;
      cfg_r.idle_ticks   <= RST_IDLE_TICKS;
      cfg_r.max_requests <= RST_MAX_REQUESTS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SERVER_IP:    server_ip_r        <= cfg_wdata;
        CFG_SERVER_PORT:  cfg_r.server_port  <= cfg_wdata[15:0];
        CFG_RETRY_TICKS:  cfg_r.retry_ticks  <= cfg_wdata[15:0];
        CFG_IDLE_TICKS:   cfg_r.idle_ticks   <= cfg_wdata[15:0];
        CFG_MAX_REQUESTS: cfg_r.max_requests <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;

  trce_front u_front (
    .in_data   (in_data),
    .server_ip (server_ip_r),
    .ev        (front_ev)
  );

  trce_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !q_full),
    .push_data (front_ev),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop_data  (queue_ev)
  );

  trce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (q_not_empty),
    .ev        (queue_ev),
    .ev_pop    (q_pop),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
